FILE: hw/rtl/mbus_pkg.sv
`timescale 1ns / 1ps
// Package for the memory bus: command and operation codes, the queue entry
// and control structs, register addresses and the boot image. No dependencies.
package mbus_pkg;

   localparam int ADDR_W         = 16;
   localparam int MEM_DEPTH      = 65536;
   localparam int OAM_BYTES_DEF  = 160;
   localparam int BOOT_BYTES_DEF = 256;
   localparam int OAM_BASE_DEF   = 65024;

   localparam logic [ADDR_W-1:0] ADDR_JOYP = 16'hFF00;
   localparam logic [ADDR_W-1:0] ADDR_DIV  = 16'hFF04;
   localparam logic [ADDR_W-1:0] ADDR_IF   = 16'hFF0F;
   localparam logic [ADDR_W-1:0] ADDR_DMA  = 16'hFF46;

   localparam logic [7:0] IF_FILL     = 8'hE0;
   localparam logic [7:0] ACTION_TAG  = 8'h20;
   localparam logic [7:0] DIR_TAG     = 8'h10;
   localparam logic [7:0] JOYP_RESET  = 8'h3F;
   localparam logic [7:0] IF_RESET    = 8'hE0;

   typedef enum logic [2:0] {
      CMD_READ   = 3'd0,
      CMD_WRITE  = 3'd1,
      CMD_LOAD   = 3'd2,
      CMD_SETDIV = 3'd3,
      CMD_BUTTON = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      OP_NOP       = 3'd0,
      OP_READ_MEM  = 3'd1,
      OP_READ_JOYP = 3'd2,
      OP_WRITE     = 3'd3,
      OP_JOYP_SEL  = 3'd4,
      OP_BUTTON    = 3'd5,
      OP_DMA       = 3'd6
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   addr;
      logic [7:0]          data;
   } entry_type;

   typedef struct packed {
      logic pop;
      logic init_busy;
   } back_ctrl_type;

   localparam logic [7:0] BOOT_IMAGE [256] = '{
      8'h31,8'hfe,8'hff,8'haf,8'h21,8'hff,8'h9f,8'h32,8'hcb,8'h7c,8'h20,8'hfb,8'h21,8'h26,8'hff,8'h0e,
      8'h11,8'h3e,8'h80,8'h32,8'he2,8'h0c,8'h3e,8'hf3,8'he2,8'h32,8'h3e,8'h77,8'h77,8'h3e,8'hfc,8'he0,
      8'h47,8'h11,8'h04,8'h01,8'h21,8'h10,8'h80,8'h1a,8'hcd,8'h95,8'h00,8'hcd,8'h96,8'h00,8'h13,8'h7b,
      8'hfe,8'h34,8'h20,8'hf3,8'h11,8'hd8,8'h00,8'h06,8'h08,8'h1a,8'h13,8'h22,8'h23,8'h05,8'h20,8'hf9,
      8'h3e,8'h19,8'hea,8'h10,8'h99,8'h21,8'h2f,8'h99,8'h0e,8'h0c,8'h3d,8'h28,8'h08,8'h32,8'h0d,8'h20,
      8'hf9,8'h2e,8'h0f,8'h18,8'hf3,8'h67,8'h3e,8'h64,8'h57,8'he0,8'h42,8'h3e,8'h91,8'he0,8'h40,8'h04,
      8'h1e,8'h02,8'h0e,8'h0c,8'hf0,8'h44,8'hfe,8'h90,8'h20,8'hfa,8'h0d,8'h20,8'hf7,8'h1d,8'h20,8'hf2,
      8'h0e,8'h13,8'h24,8'h7c,8'h1e,8'h83,8'hfe,8'h62,8'h28,8'h06,8'h1e,8'hc1,8'hfe,8'h64,8'h20,8'h06,
      8'h7b,8'he2,8'h0c,8'h3e,8'h87,8'he2,8'hf0,8'h42,8'h90,8'he0,8'h42,8'h15,8'h20,8'hd2,8'h05,8'h20,
      8'h4f,8'h16,8'h20,8'h18,8'hcb,8'h4f,8'h06,8'h04,8'hc5,8'hcb,8'h11,8'h17,8'hc1,8'hcb,8'h11,8'h17,
      8'h05,8'h20,8'hf5,8'h22,8'h23,8'h22,8'h23,8'hc9,8'hce,8'hed,8'h66,8'h66,8'hcc,8'h0d,8'h00,8'h0b,
      8'h03,8'h73,8'h00,8'h83,8'h00,8'h0c,8'h00,8'h0d,8'h00,8'h08,8'h11,8'h1f,8'h88,8'h89,8'h00,8'h0e,
      8'hdc,8'hcc,8'h6e,8'he6,8'hdd,8'hdd,8'hd9,8'h99,8'hbb,8'hbb,8'h67,8'h63,8'h6e,8'h0e,8'hec,8'hcc,
      8'hdd,8'hdc,8'h99,8'h9f,8'hbb,8'hb9,8'h33,8'h3e,8'h3c,8'h42,8'hb9,8'ha5,8'hb9,8'ha5,8'h42,8'h3c,
      8'h21,8'h04,8'h01,8'h11,8'ha8,8'h00,8'h1a,8'h13,8'hbe,8'h20,8'hfe,8'h23,8'h7d,8'hfe,8'h34,8'h20,
      8'hf5,8'h06,8'h19,8'h78,8'h86,8'h23,8'h05,8'h20,8'hfb,8'h86,8'h20,8'hfe,8'h3e,8'h01,8'he0,8'h50
   };

   function automatic logic [7:0] init_byte(input logic [ADDR_W-1:0] a, input int boot_bytes);
      logic [7:0] v;
      v = 8'h00;
      if (32'(a) < 32'(boot_bytes)) begin
         v = BOOT_IMAGE[a[7:0]];
      end else if (a == ADDR_JOYP) begin
         v = JOYP_RESET;
      end else if (a == ADDR_IF) begin
         v = IF_RESET;
      end
      return v;
   endfunction

endpackage

FILE: hw/rtl/memory_bus_with_joypad_and_oam_dma.sv
`timescale 1ns / 1ps
// Top level of the memory bus with joypad and object-memory DMA.
// Depends on mbus_pkg, mbus_front and mbus_back.
//
// A command beat is taken on req_* at a rising edge where start is high and
// busy is low. Every command gives exactly one result beat: rsp_strobe is
// high for one cycle with rsp_read_data, which is the byte read for a read
// and zero otherwise. The receiver cannot stall the result.
// The front end classifies commands into a two-entry queue; busy rises when
// the queue is full. The back end owns the 64 KiB RAM and the joypad state.
// A memory read passes through a read state for the registered RAM port,
// and a write to the DMA register copies OAM_BYTES bytes, one byte per cycle,
// through the single RAM read and write ports. The back end takes one command
// per cycle for writes and joypad operations; it takes no new command while
// a memory read or an object-memory copy is under way.
// After reset the back end writes every RAM address with its reset value
// (zeros, the boot image, the joypad and interrupt flag registers); busy
// stays high for that whole pass.
module memory_bus_with_joypad_and_oam_dma #(
   parameter int OAM_BYTES  = mbus_pkg::OAM_BYTES_DEF,
   parameter int BOOT_BYTES = mbus_pkg::BOOT_BYTES_DEF,
   parameter int OAM_BASE   = mbus_pkg::OAM_BASE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data,
   input  logic [2:0]  req_button,
   input  logic        req_pressed,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_read_data
);

   mbus_pkg::back_ctrl_type ctrl;
   mbus_pkg::entry_type     head;
   logic                    head_valid;

   mbus_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_command (req_command),
      .req_address (req_address),
      .req_data    (req_data),
      .req_button  (req_button),
      .req_pressed (req_pressed),
      .ctrl        (ctrl),
      .head_valid  (head_valid),
      .head        (head)
   );

   mbus_back #(
      .OAM_BYTES  (OAM_BYTES),
      .BOOT_BYTES (BOOT_BYTES),
      .OAM_BASE   (OAM_BASE)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head          (head),
      .ctrl          (ctrl),
      .rsp_strobe    (rsp_strobe),
      .rsp_read_data (rsp_read_data)
   );

endmodule

FILE: hw/rtl/mbus_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mbus_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

FILE: hw/rtl/mbus_front.sv
`timescale 1ns / 1ps
// Front end: accepts commands, classifies them into bus operations and holds
// them in a two-entry queue. Depends on mbus_pkg.
module mbus_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [2:0]                 req_command,
   input  logic [15:0]                req_address,
   input  logic [7:0]                 req_data,
   input  logic [2:0]                 req_button,
   input  logic                       req_pressed,
   input  mbus_pkg::back_ctrl_type    ctrl,
   output logic                       head_valid,
   output mbus_pkg::entry_type        head
);

   mbus_pkg::entry_type q_ff [2];
   logic [1:0]          count_ff, count_in;
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   mbus_pkg::entry_type entry;
   logic                push;
   logic                pop;

   always_comb begin
      entry.op   = mbus_pkg::OP_NOP;
      entry.addr = req_address;
      entry.data = req_data;
      unique case (mbus_pkg::cmd_type'(req_command))
         mbus_pkg::CMD_READ: begin
            entry.op = (req_address == mbus_pkg::ADDR_JOYP) ?
                       mbus_pkg::OP_READ_JOYP : mbus_pkg::OP_READ_MEM;
         end
         mbus_pkg::CMD_WRITE: begin
            if (!req_address[15]) begin
               entry.op = mbus_pkg::OP_NOP;
            end else if (req_address == mbus_pkg::ADDR_JOYP) begin
               entry.op = mbus_pkg::OP_JOYP_SEL;
            end else if (req_address == mbus_pkg::ADDR_DIV) begin
               entry.op   = mbus_pkg::OP_WRITE;
               entry.data = 8'h00;
            end else if (req_address == mbus_pkg::ADDR_IF) begin
               entry.op   = mbus_pkg::OP_WRITE;
               entry.data = req_data | mbus_pkg::IF_FILL;
            end else if (req_address == mbus_pkg::ADDR_DMA) begin
               entry.op = mbus_pkg::OP_DMA;
            end else begin
               entry.op = mbus_pkg::OP_WRITE;
            end
         end
         mbus_pkg::CMD_LOAD: begin
            entry.op = mbus_pkg::OP_WRITE;
         end
         mbus_pkg::CMD_SETDIV: begin
            entry.op   = mbus_pkg::OP_WRITE;
            entry.addr = mbus_pkg::ADDR_DIV;
         end
         mbus_pkg::CMD_BUTTON: begin
            entry.op   = mbus_pkg::OP_BUTTON;
            entry.data = {4'b0000, req_pressed, req_button};
         end
         default: begin
            entry.op = mbus_pkg::OP_NOP;
         end
      endcase
   end

   assign busy       = (count_ff == 2'd2) || ctrl.init_busy;
   assign push       = start && !busy;
   assign head_valid = (count_ff != 2'd0);
   assign head       = q_ff[rd_ptr_ff];
   assign pop        = ctrl.pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

FILE: hw/rtl/mbus_back.sv
`timescale 1ns / 1ps
// Back end: runs the memory initialisation pass, carries out queued bus
// operations and the object-memory copy, and drives the result beat.
// Depends on mbus_pkg and mbus_ram.
module mbus_back #(
   parameter int OAM_BYTES  = mbus_pkg::OAM_BYTES_DEF,
   parameter int BOOT_BYTES = mbus_pkg::BOOT_BYTES_DEF,
   parameter int OAM_BASE   = mbus_pkg::OAM_BASE_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  mbus_pkg::entry_type     head,
   output mbus_pkg::back_ctrl_type ctrl,
   output logic                    rsp_strobe,
   output logic [7:0]              rsp_read_data
);

   localparam int                        AW        = mbus_pkg::ADDR_W;
   localparam int                        CNT_W     = $clog2(OAM_BYTES + 1);
   localparam logic [AW-1:0]             OAM_BASE_A = AW'(OAM_BASE);
   localparam logic [CNT_W-1:0]          OAM_LAST  = CNT_W'(OAM_BYTES);

   typedef enum logic [4:0] {
      ST_INIT    = 5'b00001,
      ST_IDLE    = 5'b00010,
      ST_READ    = 5'b00100,
      ST_DMA     = 5'b01000,
      ST_DMA_END = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [AW-1:0]    init_cnt_ff, init_cnt_in;
   logic [CNT_W-1:0] dma_cnt_ff, dma_cnt_in;
   logic [7:0]       dma_page_ff, dma_page_in;
   logic [3:0]       dir_nib_ff, dir_nib_in;
   logic [3:0]       act_nib_ff, act_nib_in;
   logic             dir_sel_ff, dir_sel_in;
   logic             act_sel_ff, act_sel_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic             bypass_ff, bypass_in;
   logic [7:0]       bypass_data_ff;

   logic             we;
   logic [AW-1:0]    waddr;
   logic [7:0]       wdata;
   logic [AW-1:0]    raddr;
   logic [7:0]       ram_rdata;
   logic [7:0]       rdata_eff;
   logic [3:0]       btn_mask;
   logic             pop;

   mbus_ram #(
      .WIDTH (8),
      .DEPTH (mbus_pkg::MEM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (ram_rdata)
   );

   assign rdata_eff = bypass_ff ? bypass_data_ff : ram_rdata;
   assign btn_mask  = 4'b0001 << head.data[1:0];
   assign bypass_in = we && (waddr == raddr);

   always_comb begin
      state_in      = state_ff;
      init_cnt_in   = init_cnt_ff;
      dma_cnt_in    = dma_cnt_ff;
      dma_page_in   = dma_page_ff;
      dir_nib_in    = dir_nib_ff;
      act_nib_in    = act_nib_ff;
      dir_sel_in    = dir_sel_ff;
      act_sel_in    = act_sel_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = 8'h00;
      we            = 1'b0;
      waddr         = head.addr;
      wdata         = head.data;
      raddr         = head.addr;
      pop           = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            we          = 1'b1;
            waddr       = init_cnt_ff;
            wdata       = mbus_pkg::init_byte(init_cnt_ff, BOOT_BYTES);
            init_cnt_in = init_cnt_ff + 1'b1;
            if (init_cnt_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head_valid) begin
               pop           = 1'b1;
               rsp_strobe_in = 1'b1;
               unique case (head.op)
                  mbus_pkg::OP_READ_MEM: begin
                     rsp_strobe_in = 1'b0;
                     state_in      = ST_READ;
                  end
                  mbus_pkg::OP_READ_JOYP: begin
                     if (act_sel_ff) begin
                        rsp_data_in = {4'h0, act_nib_ff} | mbus_pkg::ACTION_TAG;
                     end else if (dir_sel_ff) begin
                        rsp_data_in = {4'h0, dir_nib_ff} | mbus_pkg::DIR_TAG;
                     end
                  end
                  mbus_pkg::OP_WRITE: begin
                     we = 1'b1;
                  end
                  mbus_pkg::OP_JOYP_SEL: begin
                     dir_sel_in = ~head.data[4];
                     act_sel_in = ~head.data[5];
                  end
                  mbus_pkg::OP_BUTTON: begin
                     if (head.data[2]) begin
                        act_nib_in = head.data[3] ? (act_nib_ff & ~btn_mask)
                                                  : (act_nib_ff | btn_mask);
                     end else begin
                        dir_nib_in = head.data[3] ? (dir_nib_ff & ~btn_mask)
                                                  : (dir_nib_ff | btn_mask);
                     end
                  end
                  mbus_pkg::OP_DMA: begin
                     rsp_strobe_in = 1'b0;
                     dma_page_in   = head.data;
                     dma_cnt_in    = '0;
                     state_in      = ST_DMA;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in   = rdata_eff;
            state_in      = ST_IDLE;
         end
         ST_DMA: begin
            raddr = {dma_page_ff, 8'(dma_cnt_ff)};
            if (dma_cnt_ff != '0) begin
               we    = 1'b1;
               waddr = OAM_BASE_A + AW'(dma_cnt_ff) - 1'b1;
               wdata = rdata_eff;
            end
            if (dma_cnt_ff == OAM_LAST) begin
               state_in = ST_DMA_END;
            end else begin
               dma_cnt_in = dma_cnt_ff + 1'b1;
            end
         end
         ST_DMA_END: begin
            we            = 1'b1;
            waddr         = mbus_pkg::ADDR_DMA;
            wdata         = dma_page_ff;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         init_cnt_ff   <= '0;
         dma_cnt_ff    <= '0;
         dir_nib_ff    <= 4'hF;
         act_nib_ff    <= 4'hF;
         dir_sel_ff    <= 1'b0;
         act_sel_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         bypass_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_cnt_ff   <= init_cnt_in;
         dma_cnt_ff    <= dma_cnt_in;
         dir_nib_ff    <= dir_nib_in;
         act_nib_ff    <= act_nib_in;
         dir_sel_ff    <= dir_sel_in;
         act_sel_ff    <= act_sel_in;
         rsp_strobe_ff <= rsp_strobe_in;
         bypass_ff     <= bypass_in;
      end
   end

   always_ff @(posedge clock) begin
      dma_page_ff    <= dma_page_in;
      rsp_data_ff    <= rsp_data_in;
      bypass_data_ff <= wdata;
   end

   assign ctrl.pop       = pop;
   assign ctrl.init_busy = (state_ff == ST_INIT);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_read_data  = rsp_data_ff;

endmodule
